// File: src/ick_pkg.sv
`default_nettype none

package ick_pkg;

    localparam int KERNEL_WIDTH_DEF = 3;
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT       = 256;
    localparam int PIX_W            = 8;
    localparam int FACTOR_W         = 12;
    localparam int PROD_W           = PIX_W + 1 + FACTOR_W;
    localparam int KROWS            = 5;
    localparam int KROW_W           = 60;
    localparam int DIM_W            = 9;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 60;
    localparam int M_TUSER_W        = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_ZERO  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_FOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_WRITE
    } ick_state_t;

    typedef struct packed {
        logic clear;
        logic mac_en;
        logic tap_ok;
    } ick_cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/image_kernel_convolution.sv
`default_nettype none

// Channel   Direction  tdata          tlast       tuser
// s_        in         pixel_in       -           func (0 pixel, 1 pad)
// m_        out        pixel_out      frame_done  zero_ratio
// cfg_wr_   in         register data  -           (index on cfg_wr_index)
//
// An item that yields no result is accepted in idle and the block stays idle. An item that
// yields a result is accepted, then the line store is read once per kernel column, the sums
// ripple down the cell chain, the divider runs (ACC_W = 21 + clog2(KERNEL_WIDTH^2) numerator
// bits) and the output is loaded once it is free; a zero factor sum skips the divider.
// Reset is synchronous and active low; the line store is not cleared.
// A finished result waits in the output register while the next request is accepted.

module image_kernel_convolution #(
    parameter int KERNEL_WIDTH = ick_pkg::KERNEL_WIDTH_DEF,
    parameter int MAX_WIDTH    = ick_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ick_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel_in
    input  wire logic                              s_tuser,   // [0] func
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ick_pkg::PIX_W-1:0]              m_tdata,   // [7:0] pixel_out
    output logic                                   m_tlast,
    output logic [ick_pkg::M_TUSER_W-1:0]          m_tuser,   // [0] zero_ratio
    input  wire logic                              cfg_wr_en,
    input  wire logic [ick_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [ick_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    import ick_pkg::*;

    localparam int KRAD    = KERNEL_WIDTH / 2;
    localparam int LAG     = KERNEL_WIDTH - 1 - KRAD;
    localparam int RING    = KERNEL_WIDTH + 1;
    localparam int RING_W  = $clog2(RING);
    localparam int RS_W    = RING_W + 3;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int COL_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2 * KERNEL_WIDTH + 2);
    localparam int OX_W    = COL_W + 2;
    localparam int OY_W    = ROW_W + 2;
    localparam int DX_W    = (KERNEL_WIDTH > 1) ? $clog2(KERNEL_WIDTH) : 1;
    localparam int SC_W    = $clog2(KERNEL_WIDTH + 2);
    localparam int TAP_W   = $clog2(KERNEL_WIDTH * KERNEL_WIDTH);
    localparam int ACC_W   = PROD_W + TAP_W;
    localparam int RATIO_W = FACTOR_W + TAP_W;

    // Configuration registers.
    logic [KROW_W-1:0] kern_reg [KROWS];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KROWS; i++) begin
                kern_reg[i] <= '0;
            end
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_KERNEL_ROW_ZERO:  kern_reg[0] <= cfg_wr_data;
                REG_KERNEL_ROW_ONE:   kern_reg[1] <= cfg_wr_data;
                REG_KERNEL_ROW_TWO:   kern_reg[2] <= cfg_wr_data;
                REG_KERNEL_ROW_THREE: kern_reg[3] <= cfg_wr_data;
                REG_KERNEL_ROW_FOUR:  kern_reg[4] <= cfg_wr_data;
                REG_IMAGE_WIDTH:      width_reg   <= cfg_wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:     height_reg  <= cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COL_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic signed [OX_W-1:0] w_s;
    logic signed [OY_W-1:0] h_s;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = COL_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign w_s = $signed(OX_W'(w_eff));
    assign h_s = $signed(OY_W'(h_eff));

    // Control registers.
    ick_state_t        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [RING_W-1:0] ring_reg, ring_next;
    logic [DX_W-1:0]   dx_cnt_reg;
    logic [SC_W-1:0]   sum_cnt_reg;
    logic              rd_vld_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    // Per-request working registers.
    logic signed [OX_W-1:0] ox_reg;
    logic [KERNEL_WIDTH-1:0] row_ok_reg;
    logic [RING_W-1:0]      ring_sel_reg [KERNEL_WIDTH];
    logic                   fdone_reg;
    logic                   res_zero_reg;
    logic [DX_W-1:0]        rd_dx_reg;
    logic                   rd_colok_reg;
    logic [PIX_W-1:0]       m_tdata_reg;
    logic                   m_tlast_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    // Position and window bookkeeping for the request on the input.
    logic [COL_W-1:0]        c1;
    logic [ROW_W-1:0]        r1;
    logic [RING_W-1:0]       p1;
    logic signed [OX_W-1:0]  ox_v;
    logic signed [OY_W-1:0]  oy_v;
    logic [KERNEL_WIDTH-1:0] row_ok_v;
    logic [RING_W-1:0]       ring_sel_v [KERNEL_WIDTH];
    logic                    emit_v;
    logic                    fdone_v;
    logic                    restart_v;
    logic                    store_v;

    always_comb begin
        logic [RS_W-1:0]        brw;
        logic [RS_W-1:0]        span;
        logic [RS_W-1:0]        tmp;
        logic signed [OY_W-1:0] ky;
        logic [COL_W-1:0]       c2;

        if (col_reg >= w_eff) begin
            c1 = '0;
            r1 = row_reg + 1'b1;
            p1 = (ring_reg == RING_W'(RING - 1)) ? '0 : ring_reg + 1'b1;
        end else begin
            c1 = col_reg;
            r1 = row_reg;
            p1 = ring_reg;
        end

        store_v = {1'b0, r1} < (ROW_W + 1)'(h_eff);

        ox_v = $signed({2'b00, c1}) - $signed(OX_W'(LAG));
        oy_v = $signed({2'b00, r1}) - $signed(OY_W'(LAG));
        brw  = '0;
        for (int i = 0; i < LAG; i++) begin
            if (ox_v < 0) begin
                ox_v = ox_v + w_s;
                oy_v = oy_v - $signed(OY_W'(1));
                brw  = brw + 1'b1;
            end
        end

        for (int dy = 0; dy < KERNEL_WIDTH; dy++) begin
            ky = oy_v - $signed(OY_W'(KRAD)) + $signed(OY_W'(dy));
            row_ok_v[dy] = (ky >= 0) && (ky < h_s);
            span = RS_W'(LAG) + brw + RS_W'(KRAD) - RS_W'(dy);
            tmp  = RS_W'(p1) + RS_W'(2 * RING) - span;
            for (int j = 0; j < 2; j++) begin
                if (tmp >= RS_W'(RING)) begin
                    tmp = tmp - RS_W'(RING);
                end
            end
            ring_sel_v[dy] = tmp[RING_W-1:0];
        end

        emit_v    = (oy_v >= 0) && (oy_v < h_s);
        fdone_v   = (oy_v == h_s - $signed(OY_W'(1))) && (ox_v == w_s - $signed(OX_W'(1)));
        restart_v = (oy_v >= 0) && ((oy_v > h_s - $signed(OY_W'(1))) || fdone_v);

        c2 = c1 + 1'b1;
        if (restart_v) begin
            col_next  = '0;
            row_next  = '0;
            ring_next = '0;
        end else if (c2 >= w_eff) begin
            col_next  = '0;
            row_next  = r1 + 1'b1;
            ring_next = (p1 == RING_W'(RING - 1)) ? '0 : p1 + 1'b1;
        end else begin
            col_next  = c2;
            row_next  = r1;
            ring_next = p1;
        end
    end

    // Line store: one RAM per ring row.
    logic [RING-1:0]   ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata [RING];
    logic              accept;

    assign ram_wdata = s_tuser ? '0 : s_tdata;

    // Read address for the current kernel column.
    logic signed [OX_W-1:0] kx;
    logic                   col_ok;

    assign kx        = ox_reg - $signed(OX_W'(KRAD)) + $signed(OX_W'(dx_cnt_reg));
    assign col_ok    = (kx >= 0) && (kx < w_s);
    assign ram_raddr = kx[ADDR_W-1:0];

    genvar gr;
    generate
        for (gr = 0; gr < RING; gr++) begin : g_ram
            assign ram_we[gr] = accept && store_v && (p1 == RING_W'(gr));
            ick_ram #(
                .WIDTH (PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .aclk  (aclk),
                .we    (ram_we[gr]),
                .waddr (c1[ADDR_W-1:0]),
                .wdata (ram_wdata),
                .raddr (ram_raddr),
                .rdata (ram_rdata[gr])
            );
        end
    endgenerate

    // Chain of kernel-row cells.
    logic signed [ACC_W-1:0]   sum_chain   [KERNEL_WIDTH + 1];
    logic signed [RATIO_W-1:0] ratio_chain [KERNEL_WIDTH + 1];

    assign sum_chain[0]   = '0;
    assign ratio_chain[0] = '0;

    genvar gc;
    generate
        for (gc = 0; gc < KERNEL_WIDTH; gc++) begin : g_cell
            ick_cell_ctrl_t cell_ctrl;
            assign cell_ctrl.clear  = accept;
            assign cell_ctrl.mac_en = rd_vld_reg;
            assign cell_ctrl.tap_ok = rd_colok_reg && row_ok_reg[gc];
            ick_cell #(
                .ACC_W   (ACC_W),
                .RATIO_W (RATIO_W),
                .DX_W    (DX_W)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl),
                .pixel     (ram_rdata[ring_sel_reg[gc]]),
                .krow      (kern_reg[gc]),
                .dx        (rd_dx_reg),
                .sum_in    (sum_chain[gc]),
                .ratio_in  (ratio_chain[gc]),
                .sum_out   (sum_chain[gc + 1]),
                .ratio_out (ratio_chain[gc + 1])
            );
        end
    endgenerate

    // Divider.
    logic             div_start;
    logic             div_busy;
    logic [PIX_W-1:0] div_quot;
    logic             sum_last;
    logic             ratio_zero;
    logic             out_free;
    logic             out_load;

    ick_div #(
        .NUM_W (ACC_W),
        .DEN_W (RATIO_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_chain[KERNEL_WIDTH]),
        .den     (ratio_chain[KERNEL_WIDTH]),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign sum_last   = sum_cnt_reg == SC_W'(KERNEL_WIDTH + 1);
    assign ratio_zero = ratio_chain[KERNEL_WIDTH] == '0;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && emit_v) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (dx_cnt_reg == DX_W'(KERNEL_WIDTH - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_last) begin
                    state_next = ratio_zero ? ST_WRITE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SUM:   div_start = sum_last && !ratio_zero;
            ST_WRITE: out_load  = out_free;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            ring_reg     <= '0;
            dx_cnt_reg   <= '0;
            sum_cnt_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= state_reg == ST_READ;
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                ring_reg   <= ring_next;
                dx_cnt_reg <= '0;
            end else if (state_reg == ST_READ) begin
                dx_cnt_reg <= dx_cnt_reg + 1'b1;
            end
            if (state_reg == ST_SUM) begin
                sum_cnt_reg <= sum_cnt_reg + 1'b1;
            end else begin
                sum_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ox_reg     <= ox_v;
            row_ok_reg <= row_ok_v;
            fdone_reg  <= fdone_v;
            for (int i = 0; i < KERNEL_WIDTH; i++) begin
                ring_sel_reg[i] <= ring_sel_v[i];
            end
        end
        rd_dx_reg    <= dx_cnt_reg;
        rd_colok_reg <= col_ok;
        if (state_reg == ST_SUM && sum_last) begin
            res_zero_reg <= ratio_zero;
        end
        if (out_load) begin
            m_tdata_reg <= res_zero_reg ? '0 : div_quot;
            m_tlast_reg <= fdone_reg;
            m_tuser_reg <= res_zero_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: src/ick_ram.sv
`default_nettype none

module ick_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/ick_cell.sv
`default_nettype none

module ick_cell #(
    parameter int ACC_W   = 25,
    parameter int RATIO_W = 16,
    parameter int DX_W    = 2
) (
    input  wire logic                         aclk,
    input  wire ick_pkg::ick_cell_ctrl_t      ctrl,
    input  wire logic [ick_pkg::PIX_W-1:0]    pixel,
    input  wire logic [ick_pkg::KROW_W-1:0]   krow,
    input  wire logic [DX_W-1:0]              dx,
    input  wire logic signed [ACC_W-1:0]      sum_in,
    input  wire logic signed [RATIO_W-1:0]    ratio_in,
    output logic signed [ACC_W-1:0]           sum_out,
    output logic signed [RATIO_W-1:0]         ratio_out
);

    import ick_pkg::*;

    logic signed [FACTOR_W-1:0] factor;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [RATIO_W-1:0]  rsum_reg, rsum_next;
    logic signed [ACC_W-1:0]    sum_out_reg;
    logic signed [RATIO_W-1:0]  ratio_out_reg;

    assign factor = $signed(krow[dx*FACTOR_W +: FACTOR_W]);
    assign prod   = $signed({1'b0, pixel}) * factor;

    always_comb begin
        acc_next  = acc_reg;
        rsum_next = rsum_reg;
        if (ctrl.clear) begin
            acc_next  = '0;
            rsum_next = '0;
        end else if (ctrl.mac_en) begin
            if (ctrl.tap_ok) begin
                acc_next = acc_reg + ACC_W'(prod);
            end
            rsum_next = rsum_reg + RATIO_W'(factor);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        rsum_reg      <= rsum_next;
        sum_out_reg   <= sum_in + acc_reg;
        ratio_out_reg <= ratio_in + rsum_reg;
    end

    assign sum_out   = sum_out_reg;
    assign ratio_out = ratio_out_reg;

endmodule

`default_nettype wire

// File: src/ick_div.sv
`default_nettype none

module ick_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [NUM_W-1:0]   num,
    input  wire logic signed [DEN_W-1:0]   den,
    output logic                           busy,
    output logic [ick_pkg::PIX_W-1:0]      quot
);

    import ick_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] q_signed;

    assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign trial    = {rem_reg, q_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};
    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num_mag;
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_signed[PIX_W-1:0];

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ick_pkg::*;

    localparam int KW   = KERNEL_WIDTH_DEF;
    localparam int KR   = KW >> 1;
    localparam int LAGK = KW - 1 - KR;
    localparam int RING = KW + 1;

    typedef struct packed {
        logic       pad;
        logic [7:0] pixel;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_done;
        logic       zero_ratio;
    } conv_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PIX_W-1:0]       m_tdata;
    logic                   m_tlast;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    image_kernel_convolution dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pixel_req_t       pending_reqs[$];
    conv_out_t        expected_pixels[$];
    logic [KROW_W-1:0] kern_rows[KROWS];
    logic [DIM_W-1:0] img_w_reg;
    logic [DIM_W-1:0] img_h_reg;
    logic [7:0]       line_mem[RING*MAX_WIDTH_DEF];
    int               col_pos;
    int               row_pos;
    int               errors = 0;
    int               reqs_taken = 0;
    int               pixels_checked = 0;
    int               frames_sent = 0;
    int               zero_sum_seen = 0;
    int               cycle_no = 0;
    int               hold_cycles = 0;
    bit               s_took = 1'b0;

    function automatic int eff_w();
        if (img_w_reg == 0) return 1;
        if (img_w_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return img_w_reg;
    endfunction

    function automatic int eff_h();
        if (img_h_reg == 0) return 1;
        if (img_h_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return img_h_reg;
    endfunction

    function automatic int factor(int dy, int dx);
        logic signed [FACTOR_W-1:0] f;
        f = kern_rows[dy][FACTOR_W*dx +: FACTOR_W];
        return int'(f);
    endfunction

    function automatic bit convolve_step(pixel_req_t req, output conv_out_t res);
        int w, h, total, lag, n, o, oy, ox, ky, kx, ratio, acc;
        bit made;
        w = eff_w();
        h = eff_h();
        total = w * h;
        lag = LAGK * w + LAGK;
        made = 1'b0;
        res = '0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        n = row_pos * w + col_pos;
        if (n < total)
            line_mem[(row_pos % RING) * MAX_WIDTH_DEF + col_pos] = req.pad ? 8'd0 : req.pixel;
        if (n >= lag) begin
            o = n - lag;
            if (o < total) begin
                oy = o / w;
                ox = o % w;
                ratio = 0;
                acc = 0;
                for (int dy = 0; dy < KW; dy++)
                    for (int dx = 0; dx < KW; dx++)
                        ratio += factor(dy, dx);
                for (int dy = 0; dy < KW; dy++) begin
                    ky = oy - KR + dy;
                    if (ky >= 0 && ky < h) begin
                        for (int dx = 0; dx < KW; dx++) begin
                            kx = ox - KR + dx;
                            if (kx >= 0 && kx < w)
                                acc += int'(line_mem[(ky % RING) * MAX_WIDTH_DEF + kx])
                                       * factor(dy, dx);
                        end
                    end
                end
                if (ratio == 0) begin
                    res.zero_ratio = 1'b1;
                end else begin
                    res.pixel = 8'((acc / ratio) & 255);
                end
                res.frame_done = (o == total - 1);
                made = 1'b1;
            end
            if (o >= total - 1) begin
                col_pos = 0;
                row_pos = 0;
                return made;
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        return made;
    endfunction

    always @(posedge aclk) begin
        conv_out_t exp_px;
        conv_out_t got;
        cycle_no <= cycle_no + 1;
        s_took = s_tvalid && s_tready && aresetn;
        if (s_took) begin
            reqs_taken++;
            if (convolve_step('{pad: s_tuser, pixel: s_tdata}, exp_px))
                expected_pixels.push_back(exp_px);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{pixel: m_tdata, frame_done: m_tlast, zero_ratio: m_tuser[0]};
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
            end else begin
                exp_px = expected_pixels.pop_front();
                pixels_checked++;
                if (exp_px.zero_ratio) zero_sum_seen++;
                if (got.pixel !== exp_px.pixel) begin
                    errors++;
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, exp_px.pixel, got.pixel);
                end
                if (got.frame_done !== exp_px.frame_done) begin
                    errors++;
                    $display("%0t: frame_done expected %0b actual %0b",
                             $time, exp_px.frame_done, got.frame_done);
                end
                if (got.zero_ratio !== exp_px.zero_ratio) begin
                    errors++;
                    $display("%0t: zero_ratio expected %0b actual %0b",
                             $time, exp_px.zero_ratio, got.zero_ratio);
                end
            end
        end
    end

    function automatic bit quiet_stretch();
        return cycle_no > 1500 && cycle_no < 3000;
    endfunction

    always @(negedge aclk) begin
        pixel_req_t nxt;
        if (aresetn && (!s_tvalid || s_took)) begin
            if (pending_reqs.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 12)) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.pixel;
                s_tuser <= nxt.pad;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stops taking results for a long while once, so the block backs up.
    always @(negedge aclk) begin
        if (cycle_no == 4000)
            hold_cycles = 400;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_stretch() || $urandom_range(99) >= 12;
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < KROWS) kern_rows[idx] = val;
        else if (idx == REG_IMAGE_WIDTH) img_w_reg = val[DIM_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT) img_h_reg = val[DIM_W-1:0];
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_kernel(int mode);
        logic [KROW_W-1:0] row;
        for (int r = 0; r < KROWS; r++) begin
            for (int c = 0; c < KROWS; c++) begin
                case (mode)
                    0: row[FACTOR_W*c +: FACTOR_W] = 12'($urandom);
                    1: row[FACTOR_W*c +: FACTOR_W] = 12'($urandom_range(4));
                    2: row[FACTOR_W*c +: FACTOR_W] = 12'h7FF;
                    3: row[FACTOR_W*c +: FACTOR_W] = 12'h800;
                    default: row[FACTOR_W*c +: FACTOR_W] = 12'($urandom_range(6)) - 12'd3;
                endcase
            end
            if (mode == 4 && r == 2) row[FACTOR_W*2 +: FACTOR_W] = '0;
            cfg_write(REG_KERNEL_ROW_ZERO + CFG_INDEX_W'(r), CFG_DATA_W'(row));
        end
        if (mode == 4) begin
            row = kern_rows[2];
            row[FACTOR_W*2 +: FACTOR_W] = '0;
            for (int r = 0; r < KW; r++)
                for (int c = 0; c < KW; c++)
                    row[FACTOR_W*2 +: FACTOR_W] -= kern_rows[r][FACTOR_W*c +: FACTOR_W];
            cfg_write(REG_KERNEL_ROW_TWO, CFG_DATA_W'(row));
        end
    endtask

    task automatic send_frame(int pad_pct);
        pixel_req_t req;
        int total, extra;
        total = eff_w() * eff_h();
        extra = LAGK * eff_w() + LAGK;
        for (int i = 0; i < total + extra; i++) begin
            req.pixel = $urandom_range(5) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                               : 8'($urandom);
            if (i < total) req.pad = $urandom_range(99) < pad_pct;
            else req.pad = $urandom_range(9) != 0;
            pending_reqs.push_back(req);
        end
        frames_sent++;
        wait_idle();
    endtask

    initial begin
        for (int r = 0; r < KROWS; r++) kern_rows[r] = '0;
        img_w_reg = 9'd256;
        img_h_reg = 9'd256;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < RING * MAX_WIDTH_DEF; i++) line_mem[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cfg_write(REG_IMAGE_WIDTH, 60'd3);
        cfg_write(REG_IMAGE_HEIGHT, 60'd2);
        send_frame(20);
        set_kernel(1);
        send_frame(20);
        set_kernel(2);
        send_frame(0);
        cfg_write(REG_IMAGE_WIDTH, 60'd2);
        set_kernel(3);
        send_frame(30);

        cfg_write(REG_IMAGE_WIDTH, 60'd0);
        cfg_write(REG_IMAGE_HEIGHT, 60'd300);
        set_kernel(0);
        send_frame(5);
        cfg_write(REG_IMAGE_WIDTH, 60'd400);
        cfg_write(REG_IMAGE_HEIGHT, 60'd1);
        set_kernel(1);
        send_frame(5);
        cfg_write(REG_IMAGE_WIDTH, 60'd9);
        cfg_write(REG_IMAGE_HEIGHT, 60'd4);
        set_kernel(4);
        send_frame(5);

        while (reqs_taken < 950) begin
            cfg_write(REG_IMAGE_WIDTH, 60'($urandom_range(1, 9)));
            cfg_write(REG_IMAGE_HEIGHT, 60'($urandom_range(1, 8)));
            set_kernel($urandom_range(9) < 5 ? 1 : $urandom_range(4));
            send_frame(8);
        end

        wait_idle();
        $display("Sent %0d requests in %0d frames; checked %0d pixels, %0d with zero kernel sum.",
                 reqs_taken, frames_sent, pixels_checked, zero_sum_seen);
        if (errors == 0) begin
            $display("PASS image_kernel_convolution");
        end else begin
            $display("FAIL image_kernel_convolution");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("FAIL image_kernel_convolution");
        $finish;
    end

endmodule

`default_nettype wire
